[rtl/thbs_pkg.sv]
// shared constants, types and the quarter-wave sine table of the beep synthesizer
package thbs_pkg;

   localparam int SINE_TABLE_BITS = 10;
   localparam int PHASE_BITS      = 32;
   localparam int MAX_DURATION_MS = 100;

   localparam int QUARTER_LEN = 1 << (SINE_TABLE_BITS - 2);
   localparam int QIDX_W      = SINE_TABLE_BITS - 1;

   localparam int FREQ_W   = 16;
   localparam int DUR_W    = 16;
   localparam int SAMPLE_W = 16;
   localparam int RATE_W   = 17;
   localparam int VOL_W    = 7;
   localparam int AMP_W    = 14;
   localparam int FRAME_W  = 16;
   localparam int ENV_W    = 17;
   localparam int DURC_W   = $clog2(MAX_DURATION_MS + 1);
   localparam int PROD_W   = RATE_W + DURC_W;
   localparam int ENV_NUM_W  = FRAME_W + 7;
   localparam int ENV_FRAC   = 16;
   localparam int WAVE_W     = 34;
   localparam int MAG_W      = 32;
   localparam int ENVAMP_W   = ENV_W + AMP_W;
   localparam int MULT_W     = MAG_W + ENVAMP_W;
   localparam int RES_SHIFT  = 47;

   localparam int DIV_W     = (FREQ_W + PHASE_BITS > ENV_NUM_W + ENV_FRAC) ?
                              FREQ_W + PHASE_BITS : ENV_NUM_W + ENV_FRAC;
   localparam int DIV_DEN_W = 21;
   localparam int DIV_CNT_W = $clog2(DIV_W + 1);

   localparam int MIN_FREQ   = 200;
   localparam int MS_PER_S   = 1000;
   localparam int AMP_SCALE  = 150;
   localparam int VOL_MAX    = 100;
   localparam int PCT        = 100;
   localparam int UP_PCT     = 3;
   localparam int DOWN_PCT   = 28;
   localparam int HOLD_PCT   = 72;
   localparam int ENV_ONE    = 65536;
   localparam int WAVE_C1    = 47186;
   localparam int WAVE_C2    = 18350;

   // divide by 1000 as a multiply by the rounded-up reciprocal, exact for 24-bit products
   localparam int     FR_SHIFT = 34;
   localparam int     RECIP_W  = 25;
   localparam int     FRMUL_W  = PROD_W + RECIP_W;
   localparam longint FR_RECIP = ((longint'(1) << FR_SHIFT) + MS_PER_S - 1) / MS_PER_S;

   localparam int RATE_RESET = 48000;
   localparam int VOL_RESET  = 75;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam logic [1:0] REG_ENABLE = 2'd0;
   localparam logic [1:0] REG_RATE   = 2'd1;
   localparam logic [1:0] REG_VOLUME = 2'd2;

   localparam logic KIND_START = 1'b0;
   localparam logic KIND_TICK  = 1'b1;

   typedef enum logic [1:0] {
      DIV_PHASE,
      DIV_ENV
   } div_sel_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_DIV_FR,
      ST_FR_CHK,
      ST_DIV_PH,
      ST_DIV_ENV,
      ST_WAVE,
      ST_MUL,
      ST_OUT
   } ctrl_state_type;

   typedef struct packed {
      logic        load;
      logic        div_start;
      div_sel_type div_sel;
      logic        save_frames;
      logic        commit;
      logic        wave;
      logic        mul;
      logic        out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic kind;
      logic start_ok;
      logic active;
      logic env_full;
      logic div_busy;
      logic frames_zero;
      logic out_free;
   } dp_sts_type;

   typedef struct packed {
      logic              enable;
      logic [RATE_W-1:0] rate;
      logic [VOL_W-1:0]  vol;
   } cfg_type;

   typedef logic [14:0] qtab_type [QUARTER_LEN+1];

   function automatic logic [14:0] quarter_sine(int pos);
      longint unsigned u, u2, t, y;
      u  = longint'(pos) << (18 - SINE_TABLE_BITS);
      u2 = (u * u) >> 16;
      t  = 42047 - ((u2 * 4640) >> 16);
      t  = 102944 - ((u2 * t) >> 16);
      y  = (u * t) >> 16;
      y  = (y * 32767 + 32768) >> 16;
      if (y > 32767)
         y = 32767;
      return y[14:0];
   endfunction

   function automatic qtab_type build_qtab();
      qtab_type q;
      for (int i = 0; i <= QUARTER_LEN; i++)
         q[i] = quarter_sine(i);
      return q;
   endfunction

   localparam qtab_type QTAB = build_qtab();

   // full-wave lookup by mirroring and negating the quarter table
   function automatic logic signed [15:0] sine_lookup(logic [SINE_TABLE_BITS-1:0] idx);
      logic [QIDX_W-1:0] pos;
      logic [QIDX_W-1:0] mpos;
      logic [14:0]       v;
      pos  = {1'b0, idx[SINE_TABLE_BITS-3:0]};
      mpos = QIDX_W'(QUARTER_LEN) - pos;
      v    = idx[SINE_TABLE_BITS-2] ? QTAB[mpos] : QTAB[pos];
      return idx[SINE_TABLE_BITS-1] ? -$signed({1'b0, v}) : $signed({1'b0, v});
   endfunction

endpackage

[rtl/thbs_regs.sv]
// configuration registers behind the csr port
module thbs_regs import thbs_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   logic              enable_ff, enable_in;
   logic [RATE_W-1:0] rate_ff, rate_in;
   logic [VOL_W-1:0]  vol_ff, vol_in;
   logic              wr;
   logic [1:0]        idx;

   assign wr  = csr_psel && csr_penable && csr_pwrite;
   assign idx = csr_paddr[3:2];

   always_comb begin
      enable_in = enable_ff;
      rate_in   = rate_ff;
      vol_in    = vol_ff;
      if (wr) begin
         case (idx)
            REG_ENABLE: enable_in = csr_pwdata[0];
            REG_RATE:   rate_in   = csr_pwdata[RATE_W-1:0];
            REG_VOLUME: vol_in    = (csr_pwdata[VOL_W-1:0] > VOL_W'(VOL_MAX)) ?
                                    VOL_W'(VOL_MAX) : csr_pwdata[VOL_W-1:0];
            default:    ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
         rate_ff   <= RATE_W'(RATE_RESET);
         vol_ff    <= VOL_W'(VOL_RESET);
      end else begin
         enable_ff <= enable_in;
         rate_ff   <= rate_in;
         vol_ff    <= vol_in;
      end
   end

   always_comb begin
      case (idx)
         REG_ENABLE: csr_prdata = CSR_DATA_W'(enable_ff);
         REG_RATE:   csr_prdata = CSR_DATA_W'(rate_ff);
         REG_VOLUME: csr_prdata = CSR_DATA_W'(vol_ff);
         default:    csr_prdata = '0;
      endcase
   end

   assign csr_pready = 1'b1;
   assign cfg.enable = enable_ff;
   assign cfg.rate   = rate_ff;
   assign cfg.vol    = vol_ff;

endmodule

[rtl/thbs_div.sv]
// restoring divider, one quotient bit per cycle
module thbs_div import thbs_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [DIV_W-1:0]     dividend,
   input  logic [DIV_DEN_W-1:0] divisor,
   input  logic [DIV_CNT_W-1:0] count,
   output logic                 busy,
   output logic [DIV_W-1:0]     quotient
);

   logic                 busy_ff, busy_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0]     num_ff, num_in;
   logic [DIV_W-1:0]     quo_ff, quo_in;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [DIV_DEN_W:0]   trial;
   logic [DIV_DEN_W:0]   diff;
   logic                 ge;

   assign trial = {rem_ff, num_ff[DIV_W-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign ge    = trial >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = count;
         num_in  = dividend;
         quo_in  = '0;
         rem_in  = '0;
         den_in  = divisor;
      end else if (busy_ff) begin
         num_in = {num_ff[DIV_W-2:0], 1'b0};
         quo_in = {quo_ff[DIV_W-2:0], ge};
         rem_in = ge ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1))
            busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

[rtl/thbs_dp.sv]
// beep datapath: beep state, phase accumulator, envelope, sample arithmetic, output register
module thbs_dp import thbs_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  cfg_type             cfg,
   input  dp_cmd_type          cmd,
   output dp_sts_type          sts,
   input  logic                req_kind,
   input  logic [FREQ_W-1:0]   req_freq_hz,
   input  logic [DUR_W-1:0]    req_duration_ms,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [SAMPLE_W-1:0] rsp_sample,
   output logic                rsp_last_sample
);

   logic                  kind_ff;
   logic [FREQ_W-1:0]     freq_ff;
   logic [DUR_W-1:0]      dur_ff;
   logic                  active_ff;
   logic [FRAME_W-1:0]    fi_ff, tot_ff, frames_ff;
   logic [PHASE_BITS-1:0] phase_ff, step_ff;
   logic [AMP_W-1:0]      amp_ff;
   logic signed [WAVE_W-1:0] wave_ff;
   logic [ENVAMP_W-1:0]   envamp_ff;
   logic [SAMPLE_W-1:0]   res_ff;
   logic                  neg_ff;
   logic                  rsp_valid_ff;
   logic [SAMPLE_W-1:0]   sample_ff;
   logic                  last_ff;
   logic [PROD_W-1:0]     prod_ff;

   logic                  div_busy;
   logic [DIV_W-1:0]      quo;
   logic [DIV_W-1:0]      div_num;
   logic [DIV_DEN_W-1:0]  div_den;
   logic [DIV_CNT_W-1:0]  div_cnt;

   logic [DURC_W-1:0]     durc;
   logic [PROD_W-1:0]     prod;
   logic [FRMUL_W-1:0]    fr_prod;
   logic [ENV_NUM_W-1:0]  f100, t3, t72, env_num;
   logic [DIV_DEN_W-1:0]  t28, env_den;
   logic                  ramp_up, ramp_down;
   logic [ENV_W-1:0]      env;
   logic signed [15:0]    s1, s2;
   logic signed [17:0]    c1, c2;
   logic signed [WAVE_W-1:0] p1, p2;
   logic [WAVE_W-1:0]     wave_abs;
   logic [MULT_W-1:0]     mult;
   logic [FRAME_W:0]      fi_next;

   // start checks and frame count operands
   assign durc = (dur_ff > DUR_W'(MAX_DURATION_MS)) ? DURC_W'(MAX_DURATION_MS)
                                                    : dur_ff[DURC_W-1:0];
   assign prod = PROD_W'(cfg.rate) * PROD_W'(durc);
   // frame count is prod / 1000 through the reciprocal
   assign fr_prod = FRMUL_W'(prod_ff) * FRMUL_W'(FR_RECIP);

   // envelope region
   assign f100      = ENV_NUM_W'(fi_ff) * ENV_NUM_W'(PCT);
   assign t3        = ENV_NUM_W'(tot_ff) * ENV_NUM_W'(UP_PCT);
   assign t72       = ENV_NUM_W'(tot_ff) * ENV_NUM_W'(HOLD_PCT);
   assign t28       = DIV_DEN_W'(tot_ff) * DIV_DEN_W'(DOWN_PCT);
   assign ramp_up   = f100 < t3;
   assign ramp_down = f100 > t72;
   assign env_num   = ramp_up ? f100 : ENV_NUM_W'(tot_ff - fi_ff) * ENV_NUM_W'(PCT);
   assign env_den   = ramp_up ? DIV_DEN_W'(t3) : t28;

   always_comb begin
      case (cmd.div_sel)
         DIV_PHASE: begin
            div_num = {freq_ff, {(DIV_W-FREQ_W){1'b0}}};
            div_den = DIV_DEN_W'(cfg.rate);
            div_cnt = DIV_CNT_W'(FREQ_W + PHASE_BITS);
         end
         DIV_ENV: begin
            div_num = {env_num, {(DIV_W-ENV_NUM_W){1'b0}}};
            div_den = env_den;
            div_cnt = DIV_CNT_W'(ENV_NUM_W + ENV_FRAC);
         end
         default: begin
            div_num = '0;
            div_den = '0;
            div_cnt = '0;
         end
      endcase
   end

   thbs_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_num),
      .divisor  (div_den),
      .count    (div_cnt),
      .busy     (div_busy),
      .quotient (quo)
   );

   // sample arithmetic
   assign env = (!ramp_up && !ramp_down) ? ENV_W'(ENV_ONE) : quo[ENV_W-1:0];
   assign s1  = sine_lookup(phase_ff[PHASE_BITS-1 -: SINE_TABLE_BITS]);
   assign s2  = sine_lookup(phase_ff[PHASE_BITS-2 -: SINE_TABLE_BITS]);
   assign c1  = 18'sd47186;
   assign c2  = 18'sd18350;
   assign p1  = s1 * c1;
   assign p2  = s2 * c2;
   assign wave_abs = wave_ff[WAVE_W-1] ? WAVE_W'(-wave_ff) : WAVE_W'(wave_ff);
   assign mult     = MULT_W'(wave_abs[MAG_W-1:0]) * MULT_W'(envamp_ff);
   assign fi_next  = {1'b0, fi_ff} + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         fi_ff        <= '0;
         tot_ff       <= '0;
         phase_ff     <= '0;
         step_ff      <= '0;
         amp_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.commit) begin
            active_ff <= 1'b1;
            fi_ff     <= '0;
            tot_ff    <= frames_ff;
            phase_ff  <= '0;
            step_ff   <= quo[PHASE_BITS-1:0];
            amp_ff    <= AMP_W'(cfg.vol) * AMP_W'(AMP_SCALE);
         end else if (cmd.out_load) begin
            phase_ff  <= phase_ff + step_ff;
            fi_ff     <= fi_next[FRAME_W-1:0];
            active_ff <= fi_next < {1'b0, tot_ff};
         end
         if (cmd.out_load)
            rsp_valid_ff <= 1'b1;
         else if (!rsp_stall)
            rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod;
      if (cmd.load) begin
         kind_ff <= req_kind;
         freq_ff <= req_freq_hz;
         dur_ff  <= req_duration_ms;
      end
      if (cmd.save_frames)
         frames_ff <= FRAME_W'(fr_prod[FRMUL_W-1:FR_SHIFT]);
      if (cmd.wave) begin
         wave_ff   <= p1 + p2;
         envamp_ff <= ENVAMP_W'(env) * ENVAMP_W'(amp_ff);
      end
      if (cmd.mul) begin
         res_ff <= mult[RES_SHIFT +: SAMPLE_W];
         neg_ff <= wave_ff[WAVE_W-1];
      end
      if (cmd.out_load) begin
         sample_ff <= neg_ff ? -res_ff : res_ff;
         last_ff   <= fi_next == {1'b0, tot_ff};
      end
   end

   assign sts.kind        = kind_ff;
   assign sts.start_ok    = cfg.enable && (freq_ff >= FREQ_W'(MIN_FREQ)) &&
                            (dur_ff != '0) && (cfg.vol != '0);
   assign sts.active      = active_ff;
   assign sts.env_full    = !ramp_up && !ramp_down;
   assign sts.div_busy    = div_busy;
   assign sts.frames_zero = frames_ff == '0;
   assign sts.out_free    = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_sample      = sample_ff;
   assign rsp_last_sample = last_ff;

endmodule

[rtl/thbs_ctrl.sv]
// sequencing state machine for start and tick transactions
module thbs_ctrl import thbs_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  dp_sts_type sts,
   output dp_cmd_type cmd
);

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset)
         state_ff <= ST_IDLE;
      else
         state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.div_sel = DIV_PHASE;
      req_stall   = state_ff != ST_IDLE;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (sts.kind == KIND_START) begin
               if (sts.start_ok) begin
                  state_in = ST_DIV_FR;
               end else begin
                  state_in = ST_IDLE;
               end
            end else if (!sts.active) begin
               state_in = ST_IDLE;
            end else if (sts.env_full) begin
               state_in = ST_WAVE;
            end else begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = DIV_ENV;
               state_in      = ST_DIV_ENV;
            end
         end
         ST_DIV_FR: begin
            cmd.save_frames = 1'b1;
            state_in        = ST_FR_CHK;
         end
         ST_FR_CHK: begin
            if (sts.frames_zero) begin
               state_in = ST_IDLE;
            end else begin
               cmd.div_start   = 1'b1;
               cmd.div_sel     = DIV_PHASE;
               state_in        = ST_DIV_PH;
            end
         end
         ST_DIV_PH: begin
            if (!sts.div_busy) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         ST_DIV_ENV: begin
            if (!sts.div_busy)
               state_in = ST_WAVE;
         end
         ST_WAVE: begin
            cmd.wave = 1'b1;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            // wait for the output register to free up
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

[rtl/two_harmonic_beep_synth_unit.sv]
// top level of the two-harmonic beep synthesizer
// A start transaction (kind 0) arms a beep and a tick transaction (kind 1) returns one
// sample frame while the beep runs. One transaction is worked on at a time. The frame count
// comes from a reciprocal multiply, the phase step and the envelope ramps from a shared
// one-bit-per-cycle restoring divider. An accepted start saves the frame count and, unless
// it is zero, divides for the phase step; a rejected start ends after decode. A tick in
// the hold part of the envelope skips the divider, one in a ramp first divides for the
// envelope; a tick while idle returns no sample. The result waits in an output register,
// so the next transaction is accepted while it is still stalled. Configuration must be
// written through the csr port while the block is idle; the block does not enforce this.
module two_harmonic_beep_synth_unit import thbs_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_kind,
   input  logic [FREQ_W-1:0]     req_freq_hz,
   input  logic [DUR_W-1:0]      req_duration_ms,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [SAMPLE_W-1:0]   rsp_sample,
   output logic                  rsp_last_sample,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type    cfg;
   dp_cmd_type cmd;
   dp_sts_type sts;

   thbs_regs u_regs (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   thbs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   thbs_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .cmd             (cmd),
      .sts             (sts),
      .req_kind        (req_kind),
      .req_freq_hz     (req_freq_hz),
      .req_duration_ms (req_duration_ms),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_sample      (rsp_sample),
      .rsp_last_sample (rsp_last_sample)
   );

endmodule
